// ===== sv/qvr_pkg.sv =====
// ============================================================================
// qvr_pkg
// Shared widths, payload types and pipeline control types for the quaternion
// vector rotation pipeline.
// ============================================================================
package qvr_pkg;

   localparam int QUAT_W              = 16;
   localparam int VEC_W               = 16;
   localparam int ROT_W               = 17;
   localparam int DEF_QUAT_FRAC_BITS  = 14;

   // q * v products, then the sum of three of them
   localparam int PROD1_W = QUAT_W + VEC_W;
   localparam int T_W     = PROD1_W + 1;
   // t * q products, then the sum of four of them
   localparam int PROD2_W = T_W + QUAT_W;
   localparam int R_W     = PROD2_W + 2;

   typedef struct packed {
      logic signed [QUAT_W-1:0] w;
      logic signed [QUAT_W-1:0] x;
      logic signed [QUAT_W-1:0] y;
      logic signed [QUAT_W-1:0] z;
   } quat_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [VEC_W-1:0] z;
   } vec_type;

   typedef struct packed {
      logic signed [T_W-1:0] w;
      logic signed [T_W-1:0] x;
      logic signed [T_W-1:0] y;
      logic signed [T_W-1:0] z;
   } tquat_type;

   typedef struct packed {
      logic signed [R_W-1:0] x;
      logic signed [R_W-1:0] y;
      logic signed [R_W-1:0] z;
   } rvec_type;

   // load strobes for the two register stages of a product unit
   typedef struct packed {
      logic first;
      logic second;
   } adv_type;

endpackage

// ===== sv/qvr_ham_left.sv =====
// ============================================================================
// qvr_ham_left
// First Hamilton product t = q * (0, v): product stage, then sum stage.
// ============================================================================
module qvr_ham_left
   import qvr_pkg::*;
(
   input  logic      clock,
   input  adv_type   adv,
   input  quat_type  quat_i,
   input  vec_type   vec_i,
   output tquat_type t_o,
   output quat_type  quat_o
);

   logic signed [PROD1_W-1:0] p_ff [12];
   logic signed [PROD1_W-1:0] p_in [12];
   quat_type                  qa_ff;
   quat_type                  qb_ff;
   tquat_type                 t_ff;
   tquat_type                 t_in;

   always_comb begin
      // w row
      p_in[0]  = PROD1_W'(quat_i.x) * PROD1_W'(vec_i.x);
      p_in[1]  = PROD1_W'(quat_i.y) * PROD1_W'(vec_i.y);
      p_in[2]  = PROD1_W'(quat_i.z) * PROD1_W'(vec_i.z);
      // x row
      p_in[3]  = PROD1_W'(quat_i.w) * PROD1_W'(vec_i.x);
      p_in[4]  = PROD1_W'(quat_i.y) * PROD1_W'(vec_i.z);
      p_in[5]  = PROD1_W'(quat_i.z) * PROD1_W'(vec_i.y);
      // y row
      p_in[6]  = PROD1_W'(quat_i.w) * PROD1_W'(vec_i.y);
      p_in[7]  = PROD1_W'(quat_i.x) * PROD1_W'(vec_i.z);
      p_in[8]  = PROD1_W'(quat_i.z) * PROD1_W'(vec_i.x);
      // z row
      p_in[9]  = PROD1_W'(quat_i.w) * PROD1_W'(vec_i.z);
      p_in[10] = PROD1_W'(quat_i.x) * PROD1_W'(vec_i.y);
      p_in[11] = PROD1_W'(quat_i.y) * PROD1_W'(vec_i.x);
   end

   always_comb begin
      t_in.w = -T_W'(p_ff[0]) - T_W'(p_ff[1])  - T_W'(p_ff[2]);
      t_in.x =  T_W'(p_ff[3]) + T_W'(p_ff[4])  - T_W'(p_ff[5]);
      t_in.y =  T_W'(p_ff[6]) - T_W'(p_ff[7])  + T_W'(p_ff[8]);
      t_in.z =  T_W'(p_ff[9]) + T_W'(p_ff[10]) - T_W'(p_ff[11]);
   end

   always_ff @(posedge clock) begin
      if (adv.first) begin
         p_ff  <= p_in;
         qa_ff <= quat_i;
      end
      if (adv.second) begin
         t_ff  <= t_in;
         qb_ff <= qa_ff;
      end
   end

   assign t_o    = t_ff;
   assign quat_o = qb_ff;

endmodule

// ===== sv/qvr_ham_right.sv =====
// ============================================================================
// qvr_ham_right
// Second Hamilton product r = t * conj(q), vector part only: product stage,
// then sum stage.
// ============================================================================
module qvr_ham_right
   import qvr_pkg::*;
(
   input  logic      clock,
   input  adv_type   adv,
   input  tquat_type t_i,
   input  quat_type  quat_i,
   output rvec_type  r_o
);

   logic signed [PROD2_W-1:0] p_ff [12];
   logic signed [PROD2_W-1:0] p_in [12];
   rvec_type                  r_ff;
   rvec_type                  r_in;

   always_comb begin
      // r.x = -t.w*q.x + t.x*q.w - t.y*q.z + t.z*q.y
      p_in[0]  = PROD2_W'(t_i.w) * PROD2_W'(quat_i.x);
      p_in[1]  = PROD2_W'(t_i.x) * PROD2_W'(quat_i.w);
      p_in[2]  = PROD2_W'(t_i.y) * PROD2_W'(quat_i.z);
      p_in[3]  = PROD2_W'(t_i.z) * PROD2_W'(quat_i.y);
      // r.y = -t.w*q.y + t.x*q.z + t.y*q.w - t.z*q.x
      p_in[4]  = PROD2_W'(t_i.w) * PROD2_W'(quat_i.y);
      p_in[5]  = PROD2_W'(t_i.x) * PROD2_W'(quat_i.z);
      p_in[6]  = PROD2_W'(t_i.y) * PROD2_W'(quat_i.w);
      p_in[7]  = PROD2_W'(t_i.z) * PROD2_W'(quat_i.x);
      // r.z = -t.w*q.z - t.x*q.y + t.y*q.x + t.z*q.w
      p_in[8]  = PROD2_W'(t_i.w) * PROD2_W'(quat_i.z);
      p_in[9]  = PROD2_W'(t_i.x) * PROD2_W'(quat_i.y);
      p_in[10] = PROD2_W'(t_i.y) * PROD2_W'(quat_i.x);
      p_in[11] = PROD2_W'(t_i.z) * PROD2_W'(quat_i.w);
   end

   always_comb begin
      r_in.x = -R_W'(p_ff[0]) + R_W'(p_ff[1]) - R_W'(p_ff[2])  + R_W'(p_ff[3]);
      r_in.y = -R_W'(p_ff[4]) + R_W'(p_ff[5]) + R_W'(p_ff[6])  - R_W'(p_ff[7]);
      r_in.z = -R_W'(p_ff[8]) - R_W'(p_ff[9]) + R_W'(p_ff[10]) + R_W'(p_ff[11]);
   end

   always_ff @(posedge clock) begin
      if (adv.first) begin
         p_ff <= p_in;
      end
      if (adv.second) begin
         r_ff <= r_in;
      end
   end

   assign r_o = r_ff;

endmodule

// ===== sv/qvr_round_sat.sv =====
// ============================================================================
// qvr_round_sat
// Output stage: round to nearest (ties up) back to the vector's scale,
// clamp to 17 bits, flag clipping, register the result.
// ============================================================================
module qvr_round_sat
   import qvr_pkg::*;
#(
   parameter int FRAC_BITS = DEF_QUAT_FRAC_BITS
)(
   input  logic                    clock,
   input  logic                    load,
   input  rvec_type                r_i,
   output logic signed [ROT_W-1:0] rot_x,
   output logic signed [ROT_W-1:0] rot_y,
   output logic signed [ROT_W-1:0] rot_z,
   output logic                    saturated
);

   localparam int SHIFT = 2 * FRAC_BITS;
   localparam int SUM_W = ((R_W > SHIFT + 1) ? R_W : SHIFT + 1) + 1;

   localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(1) <<< (SHIFT - 1);
   localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((1 << (ROT_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(1 << (ROT_W - 1));

   logic signed [SUM_W-1:0] sh [3];
   logic signed [ROT_W-1:0] res_in [3];
   logic [2:0]              clip;
   logic signed [ROT_W-1:0] rx_ff, ry_ff, rz_ff;
   logic                    sat_ff;
   logic signed [R_W-1:0]   src [3];

   assign src[0] = r_i.x;
   assign src[1] = r_i.y;
   assign src[2] = r_i.z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sh[i] = (SUM_W'(src[i]) + HALF) >>> SHIFT;
         if (sh[i] > OUT_MAX) begin
            res_in[i] = OUT_MAX[ROT_W-1:0];
            clip[i]   = 1'b1;
         end else if (sh[i] < OUT_MIN) begin
            res_in[i] = OUT_MIN[ROT_W-1:0];
            clip[i]   = 1'b1;
         end else begin
            res_in[i] = sh[i][ROT_W-1:0];
            clip[i]   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rx_ff  <= res_in[0];
         ry_ff  <= res_in[1];
         rz_ff  <= res_in[2];
         sat_ff <= |clip;
      end
   end

   assign rot_x     = rx_ff;
   assign rot_y     = ry_ff;
   assign rot_z     = rz_ff;
   assign saturated = sat_ff;

endmodule

// ===== sv/quaternion_vector_rotate.sv =====
// ============================================================================
// quaternion_vector_rotate
// Rotates a 3-vector by a quaternion, r = q * (0,v) * conj(q), five-stage
// pipeline, one request per cycle while rsp_stall is low.
// ============================================================================
// Usage:
//   Request channel (req_*): quaternion w,x,y,z with QUAT_FRAC_BITS fraction
//   bits and an integer vector x,y,z. A request is taken at a rising edge
//   with req_valid high and req_stall low.
//   Response channel (rsp_*): rotated vector, rounded to nearest (ties up)
//   and clamped to 17 bits; rsp_saturated marks any clamped component.
//   q is used as given, not normalized: a non-unit q scales by |q|^2.
//   Stages: five register stages, a to e; a request moves through them in
//   order and the response is valid once it reaches the output register.
//   Throughput: one request per cycle while rsp_stall is low, set by the fully
//   pipelined multiplier stages (12 products per Hamilton product, all in one
//   product stage, with a sum stage after each).
//   Stall: rsp_stall holds the output register; stages behind it keep
//   advancing into empty slots, so bubbles are squeezed out, and req_stall
//   rises only when every stage holds a request. Nothing is lost or repeated.
//   Reset: synchronous, active high; clears all stage valid bits. No state
//   is carried between requests.
// ============================================================================
module quaternion_vector_rotate
   import qvr_pkg::*;
#(
   parameter int QUAT_FRAC_BITS = DEF_QUAT_FRAC_BITS
)(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [QUAT_W-1:0] req_quat_w,
   input  logic signed [QUAT_W-1:0] req_quat_x,
   input  logic signed [QUAT_W-1:0] req_quat_y,
   input  logic signed [QUAT_W-1:0] req_quat_z,
   input  logic signed [VEC_W-1:0]  req_vec_x,
   input  logic signed [VEC_W-1:0]  req_vec_y,
   input  logic signed [VEC_W-1:0]  req_vec_z,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [ROT_W-1:0]  rsp_rot_x,
   output logic signed [ROT_W-1:0]  rsp_rot_y,
   output logic signed [ROT_W-1:0]  rsp_rot_z,
   output logic                     rsp_saturated
);

   // stage valid bits: a = q*v products, b = t sums, c = t*q products,
   // d = r sums, e = output register
   logic a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff, e_vld_ff;
   logic a_vld_in, b_vld_in, c_vld_in, d_vld_in, e_vld_in;
   logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy;

   adv_type   left_adv;
   adv_type   right_adv;
   quat_type  req_quat;
   vec_type   req_vec;
   tquat_type t_val;
   quat_type  t_quat;
   rvec_type  r_val;

   // A stage may load when it is empty or its contents move on this cycle.
   assign e_rdy = !e_vld_ff || !rsp_stall;
   assign d_rdy = !d_vld_ff || e_rdy;
   assign c_rdy = !c_vld_ff || d_rdy;
   assign b_rdy = !b_vld_ff || c_rdy;
   assign a_rdy = !a_vld_ff || b_rdy;

   assign req_stall = !a_rdy;

   always_comb begin
      a_vld_in = a_rdy ? req_valid : a_vld_ff;
      b_vld_in = b_rdy ? a_vld_ff  : b_vld_ff;
      c_vld_in = c_rdy ? b_vld_ff  : c_vld_ff;
      d_vld_in = d_rdy ? c_vld_ff  : d_vld_ff;
      e_vld_in = e_rdy ? d_vld_ff  : e_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
         c_vld_ff <= c_vld_in;
         d_vld_ff <= d_vld_in;
         e_vld_ff <= e_vld_in;
      end
   end

   assign left_adv.first   = a_rdy;
   assign left_adv.second  = b_rdy;
   assign right_adv.first  = c_rdy;
   assign right_adv.second = d_rdy;

   assign req_quat.w = req_quat_w;
   assign req_quat.x = req_quat_x;
   assign req_quat.y = req_quat_y;
   assign req_quat.z = req_quat_z;
   assign req_vec.x  = req_vec_x;
   assign req_vec.y  = req_vec_y;
   assign req_vec.z  = req_vec_z;

   qvr_ham_left u_left (
      .clock  (clock),
      .adv    (left_adv),
      .quat_i (req_quat),
      .vec_i  (req_vec),
      .t_o    (t_val),
      .quat_o (t_quat)
   );

   qvr_ham_right u_right (
      .clock  (clock),
      .adv    (right_adv),
      .t_i    (t_val),
      .quat_i (t_quat),
      .r_o    (r_val)
   );

   qvr_round_sat #(
      .FRAC_BITS (QUAT_FRAC_BITS)
   ) u_round (
      .clock     (clock),
      .load      (e_rdy),
      .r_i       (r_val),
      .rot_x     (rsp_rot_x),
      .rot_y     (rsp_rot_y),
      .rot_z     (rsp_rot_z),
      .saturated (rsp_saturated)
   );

   assign rsp_valid = e_vld_ff;

endmodule
